FILE: hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REP_MAX         = 8;
  localparam int MAX_RES         = 9;
  localparam int QUEUE_DEPTH     = 10;
  localparam int OCC_W           = 4;
  localparam int RES_W           = 4;
  localparam int SUM_W           = 5;
  localparam int LEN_W           = 4;

  localparam logic [7:0] LINE_END = 8'd10;

  localparam logic [1:0] CFG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LEN   = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sfr_item_t;

endpackage

FILE: hdl/sfr_win_cell.sv
// ----------------------------------------------------------------------------
// sfr_win_cell
// One held byte of the match window with its compare against each pattern byte.
// ----------------------------------------------------------------------------
module sfr_win_cell
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   load_en,
  input  logic [7:0]             load_byte,
  input  logic [63:0]            pattern,
  output logic [7:0]             held_byte,
  output logic [PATTERN_MAX-1:0] eq
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      byte_r <= load_byte;
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      eq[k] = (byte_r == pattern[8*k +: 8]);
    end
  end

  assign held_byte = byte_r;

endmodule

FILE: hdl/sfr_out_cell.sv
// ----------------------------------------------------------------------------
// sfr_out_cell
// One stage of the result queue; shifts toward the output or takes a new result.
// ----------------------------------------------------------------------------
module sfr_out_cell
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      shift_en,
  input  sfr_item_t shift_in,
  input  logic      load_en,
  input  sfr_item_t load_item,
  output sfr_item_t item
);

  sfr_item_t item_r;
  sfr_item_t item_nxt;

  always_comb begin
    item_nxt = item_r;
    if (load_en) begin
      item_nxt = load_item;
    end else if (shift_en) begin
      item_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item = item_r;

endmodule

FILE: hdl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Replaces each leftmost occurrence of a pattern within a line by a
// replacement text, one input byte per request.
//
// The input channel carries one text byte in in_tdata and the end of stream
// flag in in_tlast. The output channel carries one rewritten byte per request,
// with out_tlast on the final byte caused by an input request. The pattern
// and replacement are set through the write port while the block is idle;
// the user must keep to this, as the block itself does not enforce it. The
// block takes one byte per cycle while each byte causes at most one result
// and the receiver takes each result; a byte that causes more results holds
// the input while they drain from the ten-stage result queue, whose fill
// level sets the input ready. When the receiver stalls, results wait in the
// queue and input stops once more than one result is waiting. Reset empties
// the window and the queue and clears the pattern and replacement settings.
// ----------------------------------------------------------------------------
module stream_find_and_replace
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  logic [63:0]      pattern_r;
  logic [LEN_W-1:0] pattern_len_r;
  logic [63:0]      replacement_r;
  logic [LEN_W-1:0] replacement_len_r;
  logic [CNT_W-1:0] win_cnt_r;
  logic [CNT_W-1:0] win_cnt_nxt;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  logic [7:0]             win_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] win_eq   [PATTERN_MAX];
  logic [7:0]             win_load [PATTERN_MAX];
  logic [7:0]             ext      [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ext_eq   [PATTERN_MAX];
  logic [PATTERN_MAX:0]   fits;

  logic [LEN_W-1:0] plen_wide;
  logic [CNT_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic [CNT_W-1:0] cnt_ext;
  logic [CNT_W-1:0] drops;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] flush_len;
  logic [LEN_W-1:0] rep_len;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] flush_rep;
  logic [RES_W-1:0] res_cnt;
  logic [SUM_W-1:0] rep_idx [MAX_RES];
  logic             is_lf;
  logic             matched;
  logic             add_lf;
  logic             accept;
  logic             pop;
  logic [OCC_W-1:0] base;

  sfr_item_t gen      [MAX_RES];
  sfr_item_t q_item   [QUEUE_DEPTH];
  sfr_item_t q_load   [QUEUE_DEPTH];
  logic      q_load_en[QUEUE_DEPTH];

  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (occ_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (occ_r <= OCC_W'(QUEUE_DEPTH - MAX_RES));
  assign base       = occ_r - OCC_W'(pop);

  always_comb begin
    plen_wide = (pattern_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_len_r;
    plen      = plen_wide[CNT_W-1:0];
    rlen      = (replacement_len_r > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX) : replacement_len_r;
  end

  // Extended window: held bytes with the new byte placed after them.
  always_comb begin
    is_lf   = (in_tdata == LINE_END);
    cnt_ext = win_cnt_r + CNT_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (win_cnt_r == CNT_W'(i)) begin
        ext[i] = in_tdata;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          ext_eq[i][k] = (in_tdata == pattern_r[8*k +: 8]);
        end
      end else begin
        ext[i]    = win_byte[i];
        ext_eq[i] = win_eq[i];
      end
    end
  end

  // A drop count s fits when the bytes left after it form a prefix of the pattern.
  always_comb begin
    for (int s = 0; s <= PATTERN_MAX; s++) begin
      fits[s] = (CNT_W'(s) <= cnt_ext) && ((cnt_ext - CNT_W'(s)) <= plen);
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (s + k < PATTERN_MAX) begin
          if (CNT_W'(s + k) < cnt_ext && !ext_eq[s + k][k]) begin
            fits[s] = 1'b0;
          end
        end
      end
    end
    drops = CNT_W'(PATTERN_MAX);
    for (int s = PATTERN_MAX; s >= 0; s--) begin
      if (fits[s]) begin
        drops = CNT_W'(s);
      end
    end
    remain  = cnt_ext - drops;
    matched = !is_lf && (plen != '0) && (remain == plen);
    add_lf  = is_lf || in_tlast;
    if (is_lf) begin
      flush_len = win_cnt_r;
    end else if (matched || !in_tlast) begin
      flush_len = drops;
    end else begin
      flush_len = cnt_ext;
    end
    rep_len   = matched ? rlen : '0;
    flush_rep = SUM_W'(flush_len) + SUM_W'(rep_len);
    total     = flush_rep + SUM_W'(add_lf);
    res_cnt   = (total > SUM_W'(MAX_RES)) ? RES_W'(MAX_RES) : total[RES_W-1:0];
  end

  // Result list: flushed window bytes, then replacement, then an optional line end.
  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      rep_idx[j] = SUM_W'(j) - SUM_W'(flush_len);
      if (j < PATTERN_MAX && SUM_W'(j) < SUM_W'(flush_len)) begin
        gen[j].data = ext[j];
      end else if (SUM_W'(j) < flush_rep) begin
        gen[j].data = replacement_r[8*rep_idx[j][2:0] +: 8];
      end else begin
        gen[j].data = LINE_END;
      end
      gen[j].last = (RES_W'(j) + RES_W'(1) == res_cnt);
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_load[i] = ext[i];
      for (int s = 0; s < PATTERN_MAX; s++) begin
        if (i + s < PATTERN_MAX && drops == CNT_W'(s)) begin
          win_load[i] = ext[i + s];
        end
      end
    end
    win_cnt_nxt = win_cnt_r;
    if (accept) begin
      win_cnt_nxt = (is_lf || in_tlast || matched) ? '0 : remain;
    end
    occ_nxt = base + (accept ? OCC_W'(res_cnt) : '0);
  end

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_win
      sfr_win_cell #(
        .PATTERN_MAX(PATTERN_MAX)
      ) u_cell (
        .clk      (clk),
        .load_en  (accept),
        .load_byte(win_load[gi]),
        .pattern  (pattern_r),
        .held_byte(win_byte[gi]),
        .eq       (win_eq[gi])
      );
    end

    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_queue
      if (gi == 0) begin : g_first
        assign q_load[gi]    = gen[0];
        assign q_load_en[gi] = accept && (base == '0) && (res_cnt != '0);
      end else if (gi < MAX_RES) begin : g_mid
        assign q_load[gi]    = (base == '0) ? gen[gi] : gen[gi-1];
        assign q_load_en[gi] = accept && (OCC_W'(gi) >= base) &&
                               (OCC_W'(gi) - base < OCC_W'(res_cnt));
      end else begin : g_tail
        assign q_load[gi]    = gen[gi-1];
        assign q_load_en[gi] = accept && (base != '0) &&
                               (OCC_W'(gi) - base < OCC_W'(res_cnt));
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_end
        sfr_out_cell u_cell (
          .clk      (clk),
          .shift_en (pop),
          .shift_in ('0),
          .load_en  (q_load_en[gi]),
          .load_item(q_load[gi]),
          .item     (q_item[gi])
        );
      end else begin : g_link
        sfr_out_cell u_cell (
          .clk      (clk),
          .shift_en (pop),
          .shift_in (q_item[gi+1]),
          .load_en  (q_load_en[gi]),
          .load_item(q_load[gi]),
          .item     (q_item[gi])
        );
      end
    end
  endgenerate

  assign out_tdata = q_item[0].data;
  assign out_tlast = q_item[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r         <= '0;
      pattern_len_r     <= '0;
      replacement_r     <= '0;
      replacement_len_r <= '0;
      win_cnt_r         <= '0;
      occ_r             <= '0;
    end else begin
      win_cnt_r <= win_cnt_nxt;
      occ_r     <= occ_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_BYTES:     pattern_r         <= cfg_data;
          CFG_PATTERN_LENGTH:    pattern_len_r     <= cfg_data[LEN_W-1:0];
          CFG_REPLACEMENT_BYTES: replacement_r     <= cfg_data;
          CFG_REPLACEMENT_LEN:   replacement_len_r <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
